### rtl/core/pcpa_pkg.sv
// ----------------------------------------------------------------------------
// pcpa_pkg: shared types and codes of the per-CPU page allocator
// Request and result structs, status and action codes, register indexes.
// ----------------------------------------------------------------------------
package pcpa_pkg;

  localparam int NUM_CPUS_DEF   = 8;
  localparam int NUM_PAGES_DEF  = 32768;
  localparam int PAGE_BYTES_DEF = 4096;

  localparam int ADDR_W     = 32;
  localparam int CPU_FLD_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [ADDR_W-1:0] REGION_START_RST = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] REGION_STOP_RST  = 32'h8800_0000;

  localparam logic ACT_FREE  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  typedef enum logic [1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_BAD_ADDR = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_START = 1'b0,
    CFG_REGION_STOP  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic                 action;
    logic [CPU_FLD_W-1:0] cpu;
    logic [ADDR_W-1:0]    page_addr;
  } pcpa_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted_addr;
    logic [1:0]        status;
  } pcpa_out_t;

  // head file write control
  typedef struct packed {
    logic we;
    logic valid;
  } hf_wr_ctl_t;

  // head file read status
  typedef struct packed {
    logic found;
    logic valid;
  } hf_rd_sts_t;

endpackage

### rtl/core/pcpa_ram.sv
// ----------------------------------------------------------------------------
// pcpa_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; read data holds without a read.
// ----------------------------------------------------------------------------
module pcpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/pcpa_head_file.sv
// ----------------------------------------------------------------------------
// pcpa_head_file: list heads and head valid bits, one per CPU
// Pick the pop source (own list, else lowest other non-empty) and read it.
// ----------------------------------------------------------------------------
module pcpa_head_file #(
  parameter int NUM_CPUS = 8,
  parameter int CPU_W    = 3,
  parameter int PAGE_W   = 15
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [CPU_W-1:0]       rd_cpu,
  input  logic                   rd_pop,
  output pcpa_pkg::hf_rd_sts_t   rd_sts,
  output logic [CPU_W-1:0]       rd_idx,
  output logic [PAGE_W-1:0]      rd_page,
  input  pcpa_pkg::hf_wr_ctl_t   wr_ctl,
  input  logic [CPU_W-1:0]       wr_idx,
  input  logic [PAGE_W-1:0]      wr_page
);
  import pcpa_pkg::*;

  logic [PAGE_W-1:0]   heads_r [NUM_CPUS];
  logic [NUM_CPUS-1:0] valid_r;
  logic [CPU_W-1:0]    other_idx;
  logic                other_any;
  logic                own_valid;

  // lowest-numbered other CPU with a non-empty list
  always_comb begin
    other_idx = '0;
    other_any = 1'b0;
    for (int i = NUM_CPUS - 1; i >= 0; i--) begin
      if (valid_r[i] && (CPU_W'(i) != rd_cpu)) begin
        other_idx = CPU_W'(i);
        other_any = 1'b1;
      end
    end
  end

  assign own_valid = valid_r[rd_cpu];

  always_comb begin
    rd_idx       = rd_cpu;
    rd_sts.found = 1'b1;
    if (rd_pop && !own_valid) begin
      rd_idx       = other_idx;
      rd_sts.found = other_any;
    end
    rd_sts.valid = valid_r[rd_idx];
    rd_page      = heads_r[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_ctl.we) begin
      valid_r[wr_idx] <= wr_ctl.valid;
    end
    if (wr_ctl.we) begin
      heads_r[wr_idx] <= wr_page;
    end
  end

endmodule

### rtl/core/per_cpu_page_allocator_core.sv
// ----------------------------------------------------------------------------
// per_cpu_page_allocator_core: per-CPU LIFO free lists of page frames
// Flow: a request is registered on acceptance and checked in ST_LOOK; a free
// or an empty alloc loads the result register from there, an alloc that pops
// first passes ST_POP (registered read of the next-link memory). Requests are
// taken one at a time, each waiting on out_stall to load the result register.
// Reset: synchronous; all lists come out empty, the link memory is not
// cleared (an entry is only read after a push wrote it).
// ----------------------------------------------------------------------------
module per_cpu_page_allocator_core #(
  parameter int NUM_CPUS   = pcpa_pkg::NUM_CPUS_DEF,
  parameter int NUM_PAGES  = pcpa_pkg::NUM_PAGES_DEF,
  // PAGE_BYTES must be a power of two
  parameter int PAGE_BYTES = pcpa_pkg::PAGE_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  pcpa_pkg::pcpa_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output pcpa_pkg::pcpa_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [pcpa_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [pcpa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import pcpa_pkg::*;

  localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int PAGE_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int OFS_W  = $clog2(PAGE_BYTES);
  localparam int LINK_W = PAGE_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_POP
  } state_t;

  // fold an out-of-range CPU number back into range (small constant table)
  function automatic logic [CPU_W-1:0] cpu_fold(input logic [CPU_FLD_W-1:0] c);
    logic [CPU_W-1:0] r;
    r = '0;
    for (int v = 0; v < (1 << CPU_FLD_W); v++) begin
      if (c == CPU_FLD_W'(v)) begin
        r = CPU_W'(v % NUM_CPUS);
      end
    end
    return r;
  endfunction

  state_t              state_r, state_nxt;
  logic                req_act_r;
  logic [CPU_W-1:0]    req_cpu_r;
  logic [ADDR_W-1:0]   req_addr_r;
  logic [CPU_W-1:0]    pop_cpu_r, pop_cpu_nxt;
  logic [PAGE_W-1:0]   pop_page_r, pop_page_nxt;
  logic                out_valid_r;
  pcpa_out_t           out_r, out_nxt;
  logic                out_load;
  logic [ADDR_W-1:0]   start_r, stop_r;

  logic                in_acc;
  logic                out_free;

  // address check
  logic [ADDR_W-1:0]   addr_ofs;
  logic [ADDR_W-1:0]   page_wide;
  logic                addr_good;
  logic [PAGE_W-1:0]   free_page;

  // head file
  hf_rd_sts_t          hf_sts;
  logic [CPU_W-1:0]    hf_idx;
  logic [PAGE_W-1:0]   hf_page;
  hf_wr_ctl_t          hf_wr;
  logic [CPU_W-1:0]    hf_wr_idx;
  logic [PAGE_W-1:0]   hf_wr_page;

  // link memory
  logic                lk_we;
  logic [PAGE_W-1:0]   lk_waddr;
  logic [LINK_W-1:0]   lk_wdata;
  logic                lk_re;
  logic [LINK_W-1:0]   lk_rdata;

  // take a request only when idle and out of reset
  assign in_stall = (state_r != ST_IDLE) || !rst_n;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // free address: aligned, in the region, and inside the link table
  assign addr_ofs  = req_addr_r - start_r;
  assign page_wide = addr_ofs >> OFS_W;
  assign free_page = page_wide[PAGE_W-1:0];
  assign addr_good = (req_addr_r[OFS_W-1:0] == '0) &&
                     (req_addr_r >= start_r) &&
                     (req_addr_r < stop_r) &&
                     (page_wide < ADDR_W'(NUM_PAGES));

  pcpa_head_file #(
    .NUM_CPUS (NUM_CPUS),
    .CPU_W    (CPU_W),
    .PAGE_W   (PAGE_W)
  ) u_heads (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_cpu  (req_cpu_r),
    .rd_pop  (req_act_r == ACT_ALLOC),
    .rd_sts  (hf_sts),
    .rd_idx  (hf_idx),
    .rd_page (hf_page),
    .wr_ctl  (hf_wr),
    .wr_idx  (hf_wr_idx),
    .wr_page (hf_wr_page)
  );

  // each entry: {next valid, next page}
  pcpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NUM_PAGES),
    .AW    (PAGE_W)
  ) u_links (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (lk_re),
    .raddr (hf_page),
    .rdata (lk_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    pop_cpu_nxt  = pop_cpu_r;
    pop_page_nxt = pop_page_r;
    out_load     = 1'b0;
    out_nxt      = '0;
    hf_wr        = '0;
    hf_wr_idx    = req_cpu_r;
    hf_wr_page   = free_page;
    lk_we        = 1'b0;
    lk_waddr     = free_page;
    lk_wdata     = {hf_sts.valid, hf_page};
    lk_re        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (req_act_r == ACT_FREE) begin
          // push: link the page to the old head, make it the new head
          if (out_free) begin
            out_load = 1'b1;
            if (addr_good) begin
              out_nxt.status = STATUS_DONE;
              lk_we          = 1'b1;
              hf_wr.we       = 1'b1;
              hf_wr.valid    = 1'b1;
            end else begin
              out_nxt.status = STATUS_BAD_ADDR;
            end
            state_nxt = ST_IDLE;
          end
        end else if (!hf_sts.found) begin
          // every list is empty
          if (out_free) begin
            out_load       = 1'b1;
            out_nxt.status = STATUS_EMPTY;
            state_nxt      = ST_IDLE;
          end
        end else begin
          // pop: fetch the link of the chosen head
          lk_re        = 1'b1;
          pop_cpu_nxt  = hf_idx;
          pop_page_nxt = hf_page;
          state_nxt    = ST_POP;
        end
      end
      ST_POP: begin
        // advance the head to the fetched link; read data holds while stalled
        if (out_free) begin
          out_load             = 1'b1;
          out_nxt.status       = STATUS_DONE;
          out_nxt.granted_addr = start_r + (ADDR_W'(pop_page_r) << OFS_W);
          hf_wr.we             = 1'b1;
          hf_wr.valid          = lk_rdata[PAGE_W];
          hf_wr_idx            = pop_cpu_r;
          hf_wr_page           = lk_rdata[PAGE_W-1:0];
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      start_r     <= REGION_START_RST;
      stop_r      <= REGION_STOP_RST;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_REGION_START: start_r <= cfg_wdata;
          CFG_REGION_STOP:  stop_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
    if (in_acc) begin
      req_act_r  <= in_data.action;
      req_cpu_r  <= cpu_fold(in_data.cpu);
      req_addr_r <= in_data.page_addr;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
    pop_cpu_r  <= pop_cpu_nxt;
    pop_page_r <= pop_page_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/core/pcpa_checker.sv
// ----------------------------------------------------------------------------
// pcpa_checker: port-level checks of the per-CPU page allocator
// Bound to the top level; watches the request and result channels.
// ----------------------------------------------------------------------------
module pcpa_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input pcpa_pkg::pcpa_out_t  out_data
);
  import pcpa_pkg::*;

  // one request in flight: stall right after taking one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in flight");

  // a failed request grants nothing
  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != STATUS_DONE)) |-> (out_data.granted_addr == '0))
    else $error("failed request carries a nonzero address");

  // a new result only appears while a request was being worked on
  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a pending request");

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind per_cpu_page_allocator_core pcpa_checker u_pcpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for per_cpu_page_allocator_core
// Drives free and alloc requests through the valid/stall channel and checks
// every granted address and status against a cycle-free model of the
// per-CPU free lists kept in the bench, over several region settings.
// ----------------------------------------------------------------------------
module tb;
  import pcpa_pkg::*;

  localparam int NUM_CPUS   = NUM_CPUS_DEF;
  localparam int NUM_PAGES  = NUM_PAGES_DEF;
  localparam int PAGE_BYTES = PAGE_BYTES_DEF;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam logic [ADDR_W-1:0] PAGE_MASK = PAGE_BYTES - 1;

  // wait after a drain; longer than an alloc takes from acceptance to result
  localparam int SETTLE_CYCLES = 4;
  // long receiver hold-off that backs the block up into its input
  localparam int HOLD_AT   = 400;
  localparam int LONG_HOLD = 300;

  // region settings walked by the random part, with request counts
  localparam int NUM_PHASES = 6;
  localparam logic [ADDR_W-1:0] PH_START [NUM_PHASES] = '{
    32'h8000_0000, 32'h0000_0000, 32'h0000_1234,
    32'hFFFF_F000, 32'hFFFF_FFFF, 32'h1000_0000
  };
  localparam logic [ADDR_W-1:0] PH_STOP [NUM_PHASES] = '{
    32'h8800_0000, 32'hFFFF_FFFF, 32'h0010_0000,
    32'hFFFF_FFFF, 32'h0000_0000, 32'h1001_0000
  };
  localparam int PH_ITEMS [NUM_PHASES] = '{400, 300, 300, 150, 100, 350};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  pcpa_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  pcpa_out_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  per_cpu_page_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Free-list model: region registers, one head per CPU, one link per page.
  // page_held tracks pages sitting in some list, so the random part can avoid
  // double frees except where it wants them.
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0] rgn_start;
  logic [ADDR_W-1:0] rgn_stop;
  bit                free_head_vld [NUM_CPUS];
  bit [15:0]         free_head     [NUM_CPUS];
  bit                page_link_vld [NUM_PAGES];
  bit [15:0]         page_link     [NUM_PAGES];
  bit                page_held     [NUM_PAGES];

  // granted address and status expected for each accepted request, oldest first
  pcpa_out_t grant_q [$];

  int err_count  = 0;
  int rx_count   = 0;
  int stall_left = 0;
  bit tx_burst   = 1'b0;
  bit rx_burst   = 1'b0;

  // Pop the head of one CPU's list; report whether the list had a page.
  function automatic bit take_page(input int unsigned c, output int unsigned pg);
    pg = 0;
    if (!free_head_vld[c]) return 1'b0;
    pg = free_head[c];
    free_head_vld[c] = page_link_vld[pg];
    free_head[c]     = page_link[pg];
    return 1'b1;
  endfunction

  // Apply one request to the lists and give back the result it must produce.
  // pg returns the page that was pushed or popped.
  function automatic pcpa_out_t predict_grant(input pcpa_in_t req, output int unsigned pg);
    pcpa_out_t         res;
    int unsigned       c;
    logic [ADDR_W-1:0] ofs;
    bit                got;
    res.granted_addr = '0;
    res.status       = STATUS_DONE;
    pg = 0;
    c  = int'(req.cpu) % NUM_CPUS;
    if (req.action == ACT_FREE) begin
      if ((req.page_addr & PAGE_MASK) != 0 || req.page_addr < rgn_start ||
          req.page_addr >= rgn_stop) begin
        res.status = STATUS_BAD_ADDR;
      end else begin
        ofs = req.page_addr - rgn_start;
        pg  = ofs >> PAGE_SHIFT;
        if (pg >= NUM_PAGES) begin
          res.status = STATUS_BAD_ADDR;
        end else begin
          // push: the new page links to the old head
          page_link_vld[pg] = free_head_vld[c];
          page_link[pg]     = free_head[c];
          free_head_vld[c]  = 1'b1;
          free_head[c]      = 16'(pg);
        end
      end
    end else begin
      // own list first, then the lowest-numbered other CPU with a page
      got = take_page(c, pg);
      for (int k = 0; k < NUM_CPUS && !got; k++) begin
        if (k != c) got = take_page(k, pg);
      end
      if (got) res.granted_addr = rgn_start + (ADDR_W'(pg) << PAGE_SHIFT);
      else res.status = STATUS_EMPTY;
    end
    return res;
  endfunction

  // Lowest page-aligned address that maps to page k under the current region.
  function automatic logic [ADDR_W-1:0] addr_of_page(input int unsigned k);
    logic [ADDR_W-1:0] a;
    a = rgn_start + (ADDR_W'(k) << PAGE_SHIFT);
    return (a + PAGE_MASK) & ~PAGE_MASK;
  endfunction

  // --------------------------------------------------------------------------
  // Random requests: mostly well-formed frees from a small page pool and
  // allocs, skewed toward low CPUs so that stealing happens often; the rest
  // are misaligned, out-of-region and raw addresses.
  // --------------------------------------------------------------------------
  function automatic pcpa_in_t rand_req(input bit allow_dup);
    pcpa_in_t    r;
    int unsigned k;
    int unsigned pick;
    pick        = $urandom_range(0, 99);
    r.cpu       = ($urandom_range(0, 1) != 0) ? 3'($urandom_range(0, 2)) :
                                                 3'($urandom_range(0, 7));
    r.page_addr = $urandom();
    r.action    = ACT_ALLOC;
    // alloc: leave the ignored address field random
    if (pick < 42) return r;
    k = (pick < 80) ? $urandom_range(0, 31) : $urandom_range(0, NUM_PAGES + 63);
    r.action = ACT_FREE;
    if (pick < 88) begin
      // turn a free of a page still on a list into an alloc, except for the
      // occasional deliberate double free
      if (k < NUM_PAGES && page_held[k] && !(allow_dup && $urandom_range(0, 3) == 0)) begin
        r.action = ACT_ALLOC;
      end else begin
        r.page_addr = addr_of_page(k);
      end
    end else if (pick < 93) begin
      r.page_addr = addr_of_page(k) | $urandom_range(1, PAGE_BYTES - 1);
    end else if (pick < 97) begin
      case ($urandom_range(0, 3))
        0: r.page_addr = addr_of_page(0) - PAGE_BYTES;
        1: r.page_addr = rgn_stop & ~PAGE_MASK;
        2: r.page_addr = (rgn_stop - 1) & ~PAGE_MASK;
        default: r.page_addr = addr_of_page(NUM_PAGES);
      endcase
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver. Called at a clock edge where the channel is free; returns
  // at the edge where the request was accepted. Draw an idle gap first, then
  // hold the request until in_stall drops.
  // --------------------------------------------------------------------------
  task automatic send_req(input pcpa_in_t req, input bit typed, input pcpa_out_t want);
    pcpa_out_t   pred;
    int unsigned pg;
    int          gap;
    if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    // advance the model in request order; typed rows keep the model in step
    pred = predict_grant(req, pg);
    if (pred.status == STATUS_DONE) page_held[pg] = (req.action == ACT_FREE);
    grant_q.push_back(typed ? want : pred);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Register write: drain every outstanding request first, then let the
  // pipeline settle so the new region never meets a request in flight.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_REGION_START) rgn_start = val;
    else rgn_stop = val;
  endtask

  // --------------------------------------------------------------------------
  // Directed table: one row is either a register write or a request; rows
  // with typed results carry values readable straight off the spec.
  // --------------------------------------------------------------------------
  typedef struct {
    bit                    is_cfg;
    cfg_idx_t              reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    pcpa_in_t              req;
    bit                    typed;
    pcpa_out_t             want;
  } stim_row_t;

  stim_row_t stim_tab [$];

  function automatic stim_row_t req_row(input logic act, input int cpu,
                                        input logic [ADDR_W-1:0] pa, input bit typed = 1'b0,
                                        input logic [ADDR_W-1:0] g = '0,
                                        input status_t st = STATUS_DONE);
    stim_row_t r;
    r.is_cfg            = 1'b0;
    r.reg_idx           = CFG_REGION_START;
    r.reg_val           = '0;
    r.req.action        = act;
    r.req.cpu           = 3'(cpu);
    r.req.page_addr     = pa;
    r.typed             = typed;
    r.want.granted_addr = g;
    r.want.status       = st;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
    stim_row_t r;
    r         = req_row(ACT_FREE, 0, '0);
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = v;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: check every accepted result against the oldest expectation,
  // and drive out_stall with a random hold-off after each result. Once, hold
  // off for a long stretch so the block fills and stalls its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    pcpa_out_t want;
    int        hold;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (grant_q.size() == 0) begin
          err_count++;
          if (err_count <= 10) begin
            $display("unexpected result: granted_addr %h status %0d",
                     out_data.granted_addr, out_data.status);
          end
        end else begin
          want = grant_q.pop_front();
          if (out_data.granted_addr !== want.granted_addr ||
              out_data.status !== want.status) begin
            err_count++;
            if (err_count <= 10) begin
              $display("mismatch: granted_addr exp %h got %h, status exp %0d got %0d",
                       want.granted_addr, out_data.granted_addr,
                       want.status, out_data.status);
            end
          end
        end
        rx_count++;
      end
      if (stall_left > 0) begin
        // count down the hold-off; release on its last cycle
        stall_left <= stall_left - 1;
        out_stall  <= (stall_left > 1);
      end else if (out_valid && !out_stall) begin
        if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
        hold = (rx_count == HOLD_AT) ? LONG_HOLD : (rx_burst ? 0 : $urandom_range(0, 6));
        stall_left <= hold;
        out_stall  <= (hold > 0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed table, random phases, drain, verdict.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    pcpa_out_t none;
    none      = '0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    rgn_start = REGION_START_RST;
    rgn_stop  = REGION_STOP_RST;

    // after reset every list is empty
    stim_tab.push_back(req_row(ACT_ALLOC, 0, 32'h0, 1'b1, 32'h0, STATUS_EMPTY));
    // bad frees: misaligned, below start, at stop, top of memory, zero
    stim_tab.push_back(req_row(ACT_FREE, 0, 32'h8000_0800, 1'b1, 32'h0, STATUS_BAD_ADDR));
    stim_tab.push_back(req_row(ACT_FREE, 2, 32'h7FFF_F000, 1'b1, 32'h0, STATUS_BAD_ADDR));
    stim_tab.push_back(req_row(ACT_FREE, 3, 32'h8800_0000, 1'b1, 32'h0, STATUS_BAD_ADDR));
    stim_tab.push_back(req_row(ACT_FREE, 4, 32'hFFFF_FFFF, 1'b1, 32'h0, STATUS_BAD_ADDR));
    stim_tab.push_back(req_row(ACT_FREE, 5, 32'h0000_0000, 1'b1, 32'h0, STATUS_BAD_ADDR));
    // first and last page of the region, popped back in LIFO order
    stim_tab.push_back(req_row(ACT_FREE, 0, 32'h8000_0000, 1'b1, 32'h0, STATUS_DONE));
    stim_tab.push_back(req_row(ACT_FREE, 0, 32'h87FF_F000, 1'b1, 32'h0, STATUS_DONE));
    stim_tab.push_back(req_row(ACT_ALLOC, 0, 32'hFFFF_FFFF, 1'b1, 32'h87FF_F000, STATUS_DONE));
    // steal from another CPU, then nothing left anywhere
    stim_tab.push_back(req_row(ACT_ALLOC, 7, 32'h0, 1'b1, 32'h8000_0000, STATUS_DONE));
    stim_tab.push_back(req_row(ACT_ALLOC, 7, 32'h0, 1'b1, 32'h0, STATUS_EMPTY));
    // steal picks the lowest-numbered CPU with pages
    stim_tab.push_back(req_row(ACT_FREE, 6, 32'h8000_3000));
    stim_tab.push_back(req_row(ACT_FREE, 3, 32'h8000_4000));
    stim_tab.push_back(req_row(ACT_ALLOC, 5, 32'h0));
    // double free: the same page goes onto two lists and comes out twice
    stim_tab.push_back(req_row(ACT_FREE, 1, 32'h8000_5000));
    stim_tab.push_back(req_row(ACT_FREE, 2, 32'h8000_5000));
    stim_tab.push_back(req_row(ACT_ALLOC, 1, 32'h0));
    stim_tab.push_back(req_row(ACT_ALLOC, 2, 32'h0));
    stim_tab.push_back(req_row(ACT_ALLOC, 2, 32'h0));
    // region spanning all of memory: page numbers past the table are rejected
    stim_tab.push_back(cfg_row(CFG_REGION_START, 32'h0000_0000));
    stim_tab.push_back(cfg_row(CFG_REGION_STOP, 32'hFFFF_FFFF));
    stim_tab.push_back(req_row(ACT_FREE, 7, 32'h0800_0000, 1'b1, 32'h0, STATUS_BAD_ADDR));
    stim_tab.push_back(req_row(ACT_FREE, 7, 32'h07FF_F000, 1'b1, 32'h0, STATUS_DONE));
    stim_tab.push_back(req_row(ACT_ALLOC, 4, 32'h5555_AAAA, 1'b1, 32'h07FF_F000, STATUS_DONE));
    stim_tab.push_back(req_row(ACT_FREE, 1, 32'h0000_0000, 1'b1, 32'h0, STATUS_DONE));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_tab[i]) begin
      if (stim_tab[i].is_cfg) begin
        write_reg(stim_tab[i].reg_idx, stim_tab[i].reg_val);
      end else begin
        send_req(stim_tab[i].req, stim_tab[i].typed, stim_tab[i].want);
      end
    end

    // random phases; allow same-list double frees only in the last one, since
    // a list that loops on itself never runs empty again
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(CFG_REGION_START, PH_START[ph]);
      write_reg(CFG_REGION_STOP, PH_STOP[ph]);
      repeat (PH_ITEMS[ph]) send_req(rand_req(ph == NUM_PHASES - 1), 1'b0, none);
    end

    // drop valid, drain, then wait out SETTLE_CYCLES watching for stray results
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("per_cpu_page_allocator_core test passed");
    end else begin
      $display("per_cpu_page_allocator_core test failed");
    end
    $finish;
  end

  // Hard stop in case a result never shows up.
  initial begin : watchdog
    #5_000_000;
    $display("per_cpu_page_allocator_core test failed");
    $finish;
  end

endmodule
